// ----- rtl/core/c5zp_pkg.sv -----
package c5zp_pkg;

    // Image geometry
    localparam int IMG_SIZE_DEF = 28;
    localparam int WIN          = 5;
    localparam int HALF_WIN     = WIN / 2;
    localparam int NUM_LINES    = WIN - 1;
    localparam int NUM_TAPS     = WIN * WIN;

    // Field and counter widths
    localparam int PIX_W   = 8;
    localparam int COL_W   = 8;
    localparam int ROW_W   = 9;
    localparam int COORD_W = 8;
    localparam int COEF_W  = 16;

    // Datapath widths
    localparam int PROD_W = 24;
    localparam int RSUM_W = 27;
    localparam int SUM_W  = 29;
    localparam int MAG_W  = 28;
    localparam int QUO_W  = 20;
    localparam int POT_W  = 21;

    // Division by 255 as a multiply by a rounded-up reciprocal
    localparam int SCALE_DIV   = 255;
    localparam int ROUND_BIAS  = SCALE_DIV / 2;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 29;
    localparam int SCALED_W    = MAG_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV));

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COEF_PER_PACK = CFG_DATA_W / COEF_W;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_TAIL = 3'd6;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             is_padding;
    } in_t;

    typedef struct packed {
        logic signed [POT_W-1:0] potential;
        logic [COORD_W-1:0]      out_row;
        logic [COORD_W-1:0]      out_col;
        logic                    frame_last;
    } out_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } meta_t;

endpackage

// ----- rtl/core/conv5x5_zero_padded_stream_top.sv -----
// Channel   Ports                         Moves
// --------  ----------------------------  ---------------------------------------
// input     s_valid s_ready s_payload     one pixel or flush tick per request
// result    m_valid m_ready m_payload     one convolution result per request
// config    cfg_wr_en cfg_index cfg_wdata coefficient pack write, no wait
//
// One request is taken every cycle unless a stalled result holds s_ready low;
// a result passes the multiply, two adder, magnitude, scaling and output stages.
// Each line buffer is one memory with one write and one prefetched read a cycle.
// Reset clears the position counters, the coefficients and the pipeline valids;
// no clearing pass, as neighbours outside the image are forced to zero.
// A stalled result holds its own stage and every full stage before it; empty stages still fill.
module conv5x5_zero_padded_stream_top
    import c5zp_pkg::*;
#(
    parameter int IMG_SIZE = IMG_SIZE_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  in_t                     s_payload,
    output logic                    m_valid,
    input  logic                    m_ready,
    output out_t                    m_payload,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    logic [COL_W-1:0]                   pc_reg, pc_next, rd_addr;
    logic [ROW_W-1:0]                   pr_reg, pr_next;
    logic [NUM_TAPS-1:0][COEF_W-1:0]    coef_reg;
    logic [WIN-2:0][PIX_W-1:0]          bot_taps_reg;
    logic [WIN-1:0][WIN-1:0][PIX_W-1:0] win_next;
    logic [PIX_W-1:0]                   line_din [NUM_LINES];
    logic [PIX_W-1:0]                   line_dout [NUM_LINES];
    logic [NUM_TAPS-1:0][PIX_W-1:0]     pix_masked;
    logic [PIX_W-1:0]                   pix_in;
    logic                               accept, flush, produce;
    logic [ROW_W:0]                     r_wide, c_wide, rr, cc;
    logic [WIN-1:0]                     row_ok, col_ok;
    meta_t                              meta;

    assign accept = s_valid && s_ready;
    assign flush  = pr_reg >= ROW_W'(IMG_SIZE);
    assign pix_in = (flush || s_payload.is_padding) ? '0 : s_payload.pixel;

    // Advance the stream position; wrap after the last flush tick
    always_comb begin
        if (pr_reg == ROW_W'(IMG_SIZE + HALF_WIN) && pc_reg == COL_W'(1)) begin
            pc_next = '0;
            pr_next = '0;
        end else if (pc_reg == COL_W'(IMG_SIZE - 1)) begin
            pc_next = '0;
            pr_next = pr_reg + 1'b1;
        end else begin
            pc_next = pc_reg + 1'b1;
            pr_next = pr_reg;
        end
    end

    assign rd_addr = accept ? pc_next : pc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
            pr_reg <= '0;
        end else if (accept) begin
            pc_reg <= pc_next;
            pr_reg <= pr_next;
        end
    end

    // Write coefficient packs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_wr_en) begin
            for (int k = 0; k < NUM_TAPS - 1; k++) begin
                if (cfg_index == CFG_IDX_W'(k / COEF_PER_PACK)) begin
                    coef_reg[k] <= cfg_wdata[COEF_W * (k % COEF_PER_PACK) +: COEF_W];
                end
            end
            if (cfg_index == CFG_COEF_TAIL) begin
                coef_reg[NUM_TAPS-1] <= cfg_wdata[COEF_W-1:0];
            end
        end
    end

    // Chain of line cells: each passes its old column content to the one above
    genvar g;
    generate
        for (g = 0; g < NUM_LINES; g++) begin : g_line
            if (g == NUM_LINES - 1) begin : g_feed
                assign line_din[g] = pix_in;
            end else begin : g_link
                assign line_din[g] = line_dout[g + 1];
            end

            c5zp_line_cell #(
                .DEPTH (IMG_SIZE)
            ) u_cell (
                .aclk      (aclk),
                .shift_en  (accept),
                .wr_addr   (pc_reg),
                .rd_addr   (rd_addr),
                .din       (line_din[g]),
                .dout      (line_dout[g]),
                .taps_next (win_next[g])
            );
        end
    endgenerate

    // Bottom window row takes the incoming pixel directly
    always_comb begin
        for (int b = 0; b < WIN - 1; b++) begin
            win_next[WIN-1][b] = bot_taps_reg[b];
        end
        win_next[WIN-1][WIN-1] = pix_in;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            bot_taps_reg <= win_next[WIN-1][WIN-1:1];
        end
    end

    // Result centre lags the stream by two rows and two columns
    assign produce = (pr_reg > ROW_W'(HALF_WIN)) ||
                     (pr_reg == ROW_W'(HALF_WIN) && pc_reg >= COL_W'(HALF_WIN));

    always_comb begin
        if (pc_reg >= COL_W'(HALF_WIN)) begin
            r_wide = (ROW_W + 1)'(pr_reg) - (ROW_W + 1)'(HALF_WIN);
            c_wide = (ROW_W + 1)'(pc_reg) - (ROW_W + 1)'(HALF_WIN);
        end else begin
            r_wide = (ROW_W + 1)'(pr_reg) - (ROW_W + 1)'(HALF_WIN + 1);
            c_wide = (ROW_W + 1)'(pc_reg) + (ROW_W + 1)'(IMG_SIZE - HALF_WIN);
        end
    end

    // Drop neighbours outside the image
    always_comb begin
        rr = '0;
        cc = '0;
        for (int a = 0; a < WIN; a++) begin
            rr        = r_wide + (ROW_W + 1)'(a);
            cc        = c_wide + (ROW_W + 1)'(a);
            row_ok[a] = rr >= (ROW_W + 1)'(HALF_WIN) && rr < (ROW_W + 1)'(IMG_SIZE + HALF_WIN);
            col_ok[a] = cc >= (ROW_W + 1)'(HALF_WIN) && cc < (ROW_W + 1)'(IMG_SIZE + HALF_WIN);
        end
        for (int a = 0; a < WIN; a++) begin
            for (int b = 0; b < WIN; b++) begin
                pix_masked[a * WIN + b] = (row_ok[a] && col_ok[b]) ? win_next[a][b] : '0;
            end
        end
    end

    assign meta.row  = r_wide[COORD_W-1:0];
    assign meta.col  = c_wide[COORD_W-1:0];
    assign meta.last = r_wide == (ROW_W + 1)'(IMG_SIZE - 1) &&
                       c_wide == (ROW_W + 1)'(IMG_SIZE - 1);

    c5zp_mac_pipe u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && produce),
        .in_ready  (s_ready),
        .in_pix    (pix_masked),
        .in_meta   (meta),
        .coef      (coef_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_payload)
    );

endmodule

// ----- rtl/core/c5zp_line_cell.sv -----
module c5zp_line_cell
    import c5zp_pkg::*;
#(
    parameter int DEPTH = IMG_SIZE_DEF
) (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [COL_W-1:0]            wr_addr,
    input  logic [COL_W-1:0]            rd_addr,
    input  logic [PIX_W-1:0]            din,
    output logic [PIX_W-1:0]            dout,
    output logic [WIN-1:0][PIX_W-1:0]   taps_next
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIX_W-1:0]            line_mem [DEPTH];
    logic [PIX_W-1:0]            rd_data_reg;
    logic [WIN-2:0][PIX_W-1:0]   taps_reg;

    // Store the pixel from below, prefetch the next column, shift the window row
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            line_mem[wr_addr[ADDR_W-1:0]] <= din;
            taps_reg                      <= taps_next[WIN-1:1];
        end
        rd_data_reg <= line_mem[rd_addr[ADDR_W-1:0]];
    end

    // Window row after the shift; the oldest tap falls off the left
    always_comb begin
        for (int b = 0; b < WIN - 1; b++) begin
            taps_next[b] = taps_reg[b];
        end
        taps_next[WIN-1] = rd_data_reg;
    end

    // Hand the line content up to the cell above
    assign dout = rd_data_reg;

endmodule

// ----- rtl/core/c5zp_mac_pipe.sv -----
module c5zp_mac_pipe
    import c5zp_pkg::*;
(
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [NUM_TAPS-1:0][PIX_W-1:0]    in_pix,
    input  meta_t                             in_meta,
    input  logic [NUM_TAPS-1:0][COEF_W-1:0]   coef,
    output logic                              out_valid,
    input  logic                              out_ready,
    output out_t                              out_data
);

    logic signed [PROD_W-1:0] prod_reg [NUM_TAPS];
    logic signed [PROD_W-1:0] prod_next [NUM_TAPS];
    logic signed [RSUM_W-1:0] rsum_reg [WIN];
    logic signed [RSUM_W-1:0] rsum_next [WIN];
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  mag_wide;
    logic [MAG_W-1:0]         mag_reg;
    logic [SCALED_W-1:0]      scaled_reg;
    logic [SCALED_W-1:0]      scaled_next;
    logic [QUO_W-1:0]         quo;
    logic [POT_W-1:0]         quo_ext;
    logic [POT_W-1:0]         pot_next;
    logic                     neg4_reg, neg5_reg;
    meta_t                    meta1_reg, meta2_reg, meta3_reg, meta4_reg, meta5_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                     rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    out_t                     out_reg;

    // Each stage moves when it is empty or the stage after it moves
    assign rdy6     = !v6_reg || out_ready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Coefficient times pixel, one multiplier per tap
    always_comb begin
        logic signed [PROD_W:0] full;
        full = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            full         = $signed(coef[k]) * $signed({1'b0, in_pix[k]});
            prod_next[k] = full[PROD_W-1:0];
        end
    end

    // Sum each kernel row
    always_comb begin
        for (int a = 0; a < WIN; a++) begin
            rsum_next[a] = '0;
            for (int b = 0; b < WIN; b++) begin
                rsum_next[a] = rsum_next[a] + RSUM_W'(prod_reg[a * WIN + b]);
            end
        end
    end

    // Sum the row sums
    always_comb begin
        sum_next = '0;
        for (int a = 0; a < WIN; a++) begin
            sum_next = sum_next + SUM_W'(rsum_reg[a]);
        end
    end

    // Magnitude plus half the divisor, so the quotient rounds to nearest
    assign mag_wide = sum_reg[SUM_W-1] ? (SUM_W'(ROUND_BIAS) - sum_reg)
                                       : (sum_reg + SUM_W'(ROUND_BIAS));

    assign scaled_next = mag_reg * RECIP;

    // Take the quotient and restore the sign
    assign quo      = scaled_reg[RECIP_SHIFT +: QUO_W];
    assign quo_ext  = {1'b0, quo};
    assign pot_next = neg5_reg ? (POT_W'(0) - quo_ext) : quo_ext;

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // Stage data
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            prod_reg  <= prod_next;
            meta1_reg <= in_meta;
        end
        if (rdy2) begin
            rsum_reg  <= rsum_next;
            meta2_reg <= meta1_reg;
        end
        if (rdy3) begin
            sum_reg   <= sum_next;
            meta3_reg <= meta2_reg;
        end
        if (rdy4) begin
            mag_reg   <= mag_wide[MAG_W-1:0];
            neg4_reg  <= sum_reg[SUM_W-1];
            meta4_reg <= meta3_reg;
        end
        if (rdy5) begin
            scaled_reg <= scaled_next;
            neg5_reg   <= neg4_reg;
            meta5_reg  <= meta4_reg;
        end
        if (rdy6) begin
            out_reg.potential  <= $signed(pot_next);
            out_reg.out_row    <= meta5_reg.row;
            out_reg.out_col    <= meta5_reg.col;
            out_reg.frame_last <= meta5_reg.last;
        end
    end

    assign out_valid = v6_reg;
    assign out_data  = out_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import c5zp_pkg::*;

    localparam int N            = IMG_SIZE_DEF;
    localparam int LAG          = 2 * N + 2;
    localparam int FRAME_TICKS  = N * N + LAG;
    localparam int PHASES       = 6;
    localparam int PHASE_TICKS  = 300;
    localparam int DIRECTED_N   = 25;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int FULL_PACKS   = NUM_TAPS / COEF_PER_PACK;

    typedef enum {ROW_NOISE, ROW_WHITE, ROW_BLACK, ROW_BINARY, ROW_DIM} row_style_t;
    typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t s_payload;
    logic m_valid;
    logic m_ready;
    out_t m_payload;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    conv5x5_zero_padded_stream_top #(.IMG_SIZE(N)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_payload(s_payload),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_payload(m_payload),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // Shadow of the block: kernel, line buffers, window and position
    int kern [NUM_TAPS];
    logic [PIX_W-1:0] line_mem [NUM_LINES * N];
    logic [PIX_W-1:0] win [WIN][WIN];
    int unsigned pos_row;
    int unsigned pos_col;
    int unsigned flush_left;

    logic [COEF_W-1:0] kern_word [NUM_TAPS];
    in_t queued_ticks [$];
    out_t due_results [$];

    // Stimulus generator position
    int unsigned gen_pos;
    int unsigned gen_frame;
    int unsigned gen_count;
    row_style_t row_style;

    // Handshake and idling state
    bit req_taken;
    int burst_left;
    int gap_left;
    int sink_left;
    sink_mode_t sink_mode;
    int unsigned cycle_count;
    int unsigned mismatch_count;

    byte unsigned dir_pix [DIRECTED_N] = '{
        255, 0, 255, 128, 1, 254, 127, 85, 170, 255, 0, 2, 4,
        8, 16, 32, 64, 251, 253, 247, 239, 223, 191, 255, 0
    };
    bit dir_pad [DIRECTED_N] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0
    };

    // Advance the shadow by one request and form the result it releases
    task automatic convolve_tick(input in_t req, output bit produced, output out_t res);
        int unsigned t;
        int unsigned col;
        int unsigned lin;
        int r;
        int c;
        int pr;
        int pc;
        logic [PIX_W-1:0] v;
        longint acc;
        longint q;
        bit flushing;
        flushing = (flush_left != 0);
        t = flushing ? N * N + (LAG - flush_left) : pos_row * N + pos_col;
        col = t % N;
        v = (flushing || req.is_padding) ? '0 : req.pixel;

        // shift the window left and take the new column from the line buffers
        for (int a = 0; a < WIN; a++) begin
            for (int b = 0; b < WIN - 1; b++)
                win[a][b] = win[a][b + 1];
            win[a][WIN - 1] = (a < NUM_LINES) ? line_mem[a * N + col] : v;
        end
        for (int a = 0; a < NUM_LINES - 1; a++)
            line_mem[a * N + col] = line_mem[(a + 1) * N + col];
        line_mem[(NUM_LINES - 1) * N + col] = v;

        if (flushing) begin
            flush_left--;
        end else begin
            pos_col++;
            if (pos_col >= N) begin
                pos_col = 0;
                pos_row++;
                if (pos_row >= N) begin
                    pos_row = 0;
                    flush_left = LAG;
                end
            end
        end

        produced = 0;
        res = '0;
        if (t >= LAG) begin
            lin = t - LAG;
            r = lin / N;
            c = lin % N;
            acc = 0;
            // mask neighbours outside the image
            for (int a = 0; a < WIN; a++) begin
                pr = r + a - HALF_WIN;
                if (pr >= 0 && pr < N) begin
                    for (int b = 0; b < WIN; b++) begin
                        pc = c + b - HALF_WIN;
                        if (pc >= 0 && pc < N)
                            acc += longint'(kern[a * WIN + b]) * longint'(win[a][b]);
                    end
                end
            end
            // divide by 255, rounding half away from zero
            q = (acc >= 0) ? (acc + ROUND_BIAS) / SCALE_DIV
                           : -((-acc + ROUND_BIAS) / SCALE_DIV);
            produced = 1;
            res.potential = POT_W'(q);
            res.out_row = COORD_W'(r);
            res.out_col = COORD_W'(c);
            res.frame_last = (r == N - 1) && (c == N - 1);
        end
    endtask

    // Write all coefficient packs and mirror them into the shadow kernel
    task automatic load_kernel();
        logic [CFG_DATA_W-1:0] pack;
        for (int p = 0; p < FULL_PACKS; p++) begin
            pack = {kern_word[4 * p + 3], kern_word[4 * p + 2],
                    kern_word[4 * p + 1], kern_word[4 * p]};
            @(negedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(p);
            cfg_wdata <= pack;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_COEF_TAIL;
        cfg_wdata <= CFG_DATA_W'(kern_word[NUM_TAPS - 1]);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        for (int k = 0; k < NUM_TAPS; k++)
            kern[k] = $signed(kern_word[k]);
    endtask

    // Pick the kernel for one phase, the extremes first
    task automatic choose_kernel(input int phase);
        int mag;
        for (int k = 0; k < NUM_TAPS; k++) begin
            case (phase)
                0: kern_word[k] = 16'h7FFF;
                1: kern_word[k] = 16'h8000;
                3: kern_word[k] = (k % 2) ? 16'h8000 : 16'h7FFF;
                4: begin
                    mag = $urandom_range(0, 4096);
                    kern_word[k] = $urandom_range(0, 1) ? COEF_W'(-mag) : COEF_W'(mag);
                end
                default: kern_word[k] = COEF_W'($urandom);
            endcase
        end
    endtask

    // Queue a run of requests that follows the frame structure
    task automatic queue_frame_ticks(input int count);
        in_t req;
        int unsigned r;
        int unsigned c;
        for (int k = 0; k < count; k++) begin
            req.pixel = PIX_W'($urandom_range(0, 255));
            req.is_padding = 1'b0;
            if (gen_pos < N * N) begin
                r = gen_pos / N;
                c = gen_pos % N;
                if (c == 0)
                    row_style = row_style_t'($urandom_range(0, 4));
                if (gen_frame == 0 && ((r >= 2 && r <= 8) || (r >= 12 && r <= 19))) begin
                    // saturated band: full windows reach the extreme sums
                    req.pixel = 8'hFF;
                end else begin
                    case (row_style)
                        ROW_WHITE:  req.pixel = 8'hFF;
                        ROW_BLACK:  req.pixel = 8'h00;
                        ROW_BINARY: req.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        ROW_DIM:    req.pixel = PIX_W'($urandom_range(0, 15));
                        default:    ;
                    endcase
                    // padding inside the image counts as a zero pixel
                    req.is_padding = ($urandom_range(0, 19) == 0);
                end
            end else begin
                // flush: mostly padding, some stray pixels that must be ignored
                if (gen_pos - N * N < 3)
                    req.pixel = 8'hFF;
                else
                    req.is_padding = ($urandom_range(0, 3) != 0);
            end
            if (gen_count < DIRECTED_N) begin
                req.pixel = dir_pix[gen_count];
                req.is_padding = dir_pad[gen_count];
            end
            queued_ticks.push_back(req);
            gen_count++;
            gen_pos++;
            if (gen_pos == FRAME_TICKS) begin
                gen_pos = 0;
                gen_frame++;
            end
        end
    endtask

    // Wait for every request to go in and every result to come out
    task automatic wait_quiet();
        do begin
            while (queued_ticks.size() != 0 || s_valid || due_results.size() != 0)
                @(negedge aclk);
            repeat (DRAIN_CYCLES) @(negedge aclk);
        end while (queued_ticks.size() != 0 || s_valid || due_results.size() != 0);
    endtask

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Record accepted requests and predict their results
    always @(posedge aclk) begin
        bit produced;
        out_t res;
        if (aresetn && s_valid && s_ready) begin
            req_taken = 1'b1;
            convolve_tick(s_payload, produced, res);
            if (produced)
                due_results.push_back(res);
        end
    end

    // Driver: bursts of requests with random gaps
    always @(negedge aclk) begin
        if (aresetn && (req_taken || !s_valid)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (queued_ticks.size() > 0) begin
                s_payload <= queued_ticks.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // Receiver: stall in segments of differing pressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_left == 0) begin
                sink_mode = sink_mode_t'($urandom_range(0, 3));
                sink_left = $urandom_range(40, 300);
            end else begin
                sink_left--;
            end
            case (sink_mode)
                SINK_OPEN:  m_ready <= 1'b1;
                SINK_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                SINK_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
                default:    m_ready <= (cycle_count % 9) < 5;
            endcase
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: potential %0d row %0d col %0d last %0b",
                             m_payload.potential, m_payload.out_row,
                             m_payload.out_col, m_payload.frame_last);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (want.potential !== m_payload.potential
                        || want.out_row !== m_payload.out_row
                        || want.out_col !== m_payload.out_col
                        || want.frame_last !== m_payload.frame_last) begin
                    if (mismatch_count < 10)
                        $display({"mismatch at (%0d,%0d): expected potential %0d row %0d",
                                  " col %0d last %0b, got potential %0d row %0d col %0d",
                                  " last %0b"},
                                 want.out_row, want.out_col, want.potential, want.out_row,
                                 want.out_col, want.frame_last, m_payload.potential,
                                 m_payload.out_row, m_payload.out_col,
                                 m_payload.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        for (int k = 0; k < NUM_TAPS; k++)
            kern[k] = 0;
        for (int k = 0; k < NUM_LINES * N; k++)
            line_mem[k] = '0;
        for (int a = 0; a < WIN; a++)
            for (int b = 0; b < WIN; b++)
                win[a][b] = '0;
        pos_row = 0;
        pos_col = 0;
        flush_left = 0;
        gen_pos = 0;
        gen_frame = 0;
        gen_count = 0;
        row_style = ROW_NOISE;
        req_taken = 1'b0;
        burst_left = 0;
        gap_left = 0;
        sink_left = 0;
        sink_mode = SINK_OPEN;
        cycle_count = 0;
        mismatch_count = 0;

        // hold reset low before releasing it
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // one kernel per phase, changed only while the block is idle
        for (int ph = 0; ph < PHASES; ph++) begin
            choose_kernel(ph);
            load_kernel();
            queue_frame_ticks(PHASE_TICKS);
            wait_quiet();
        end

        if (mismatch_count == 0 && due_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/c5zp_pkg.sv
rtl/core/c5zp_line_cell.sv
rtl/core/c5zp_mac_pipe.sv
rtl/core/conv5x5_zero_padded_stream_top.sv
tb/testbench.sv
